>>> hw/rtl/asg_pkg.sv
// ---------------------------------------------------------------------------
// asg_pkg - shared types and constants of the grid next-step planner
// Sizes of the map and search stores, cell word layout, move helpers.
// ---------------------------------------------------------------------------
package asg_pkg;

   // grid and list sizes
   localparam int COORD_W    = 5;
   localparam int GRID_SIDE  = 32;
   localparam int CELLS      = GRID_SIDE * GRID_SIDE;
   localparam int CELL_W     = 2 * COORD_W;
   localparam int LIST_DEPTH = 1024;
   localparam int LIST_W     = $clog2(LIST_DEPTH);
   localparam int CNT_W      = LIST_W + 1;
   localparam int G_W        = CELL_W;

   // fixed point heuristic
   localparam int FRAC_BITS = 32;
   localparam int F_W       = G_W + 1 + FRAC_BITS;
   localparam int SQ_STEPS  = 8 + FRAC_BITS;
   localparam int SQ_CNT_W  = $clog2(SQ_STEPS + 1);
   localparam int ROOT_W    = SQ_STEPS;
   localparam int D2_W      = 16;

   // stream words
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 16;

   localparam logic [7:0] OBSTACLE_CODE = 8'd5;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // move directions, tried in this order
   localparam int DIR_W = 2;
   localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
   localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
   localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

   typedef enum logic [1:0] {
      MARK_NONE,
      MARK_OPEN,
      MARK_CLOSED
   } mark_type;

   typedef struct packed {
      mark_type           mark;
      logic [G_W-1:0]     g;
      logic [DIR_W-1:0]   parent;
      logic [F_W-1:0]     f;
   } cell_word_type;

   typedef struct packed {
      logic               start;
      logic [COORD_W-1:0] dx;
      logic [COORD_W-1:0] dy;
   } sq_req_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [ROOT_W-1:0]  root;
   } sq_rsp_type;

   typedef struct packed {
      logic               ok;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } move_type;

   typedef enum logic [4:0] {
      S_BOOT,
      S_IDLE,
      S_CLEAR,
      S_START_H,
      S_SEL,
      S_SCAN_CELL,
      S_SCAN_CMP,
      S_POP_RD,
      S_POP_WR,
      S_CLOSE,
      S_NB_CHK,
      S_NB_TEST,
      S_NB_H,
      S_WALK_RD,
      S_WALK_STEP,
      S_REPLY
   } state_type;

   // absolute difference of two coordinates
   function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
      abs_diff = (a > b) ? (a - b) : (b - a);
   endfunction

   // one step in a direction, or against it when back is set
   function automatic move_type step_move(input logic [COORD_W-1:0] x,
                                          input logic [COORD_W-1:0] y,
                                          input logic [DIR_W-1:0]   dir,
                                          input logic               back);
      move_type         m;
      logic [DIR_W-1:0] d;
      d    = dir ^ {{(DIR_W-1){1'b0}}, back};
      m.ok = 1'b1;
      m.x  = x;
      m.y  = y;
      case (d)
         DIR_UP: begin
            m.ok = (y != COORD_W'(GRID_SIDE - 1));
            m.y  = y + COORD_W'(1);
         end
         DIR_DOWN: begin
            m.ok = (y != '0);
            m.y  = y - COORD_W'(1);
         end
         DIR_LEFT: begin
            m.ok = (x != '0);
            m.x  = x - COORD_W'(1);
         end
         DIR_RIGHT: begin
            m.ok = (x != COORD_W'(GRID_SIDE - 1));
            m.x  = x + COORD_W'(1);
         end
         default: begin
            m.ok = 1'b0;
         end
      endcase
      return m;
   endfunction

endpackage

>>> hw/rtl/asg_sqrt.sv
// ---------------------------------------------------------------------------
// asg_sqrt - iterative euclidean distance unit
// Works out floor(sqrt(dx*dx + dy*dy) * 2^FRAC_BITS), one root bit a cycle.
// ---------------------------------------------------------------------------
module asg_sqrt (
   input  logic                clock,
   input  logic                reset,
   input  asg_pkg::sq_req_type sq_req,
   output asg_pkg::sq_rsp_type sq_rsp
);
   import asg_pkg::*;

   logic [D2_W-1:0]     d2_ff,   d2_in;
   logic [ROOT_W+1:0]   rem_ff,  rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [SQ_CNT_W-1:0] step_ff, step_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [ROOT_W+1:0]   rem_sh;
   logic [ROOT_W+1:0]   trial;

   // one restoring step per cycle, digit pairs taken from the top of d2
   always_comb begin
      d2_in   = d2_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[ROOT_W-1:0], d2_ff[D2_W-1:D2_W-2]};
      trial   = {root_ff, 2'b01};
      if (sq_req.start) begin
         d2_in   = D2_W'(sq_req.dx) * D2_W'(sq_req.dx)
                 + D2_W'(sq_req.dy) * D2_W'(sq_req.dy);
         rem_in  = '0;
         root_in = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         d2_in = {d2_ff[D2_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         step_in = step_ff + SQ_CNT_W'(1);
         if (step_ff == SQ_CNT_W'(SQ_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      d2_ff   <= d2_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sq_rsp.busy = busy_ff;
   assign sq_rsp.done = done_ff;
   assign sq_rsp.root = root_ff;

endmodule

>>> hw/rtl/grid_astar_next_step.sv
// ---------------------------------------------------------------------------
// grid_astar_next_step - next step of an A* search over a 32 x 32 map
// After reset the block sweeps the obstacle map clear, one cell a cycle, over
// all 1024 cells before it takes its first word. A write word (tuser 0) stores
// one map cell and gives no result. A query word (tuser 1) runs A* over
// 4-connected moves and returns one result word: found flag and the first
// move cell. A query with start equal to target returns the start cell as
// found without a search. Otherwise it clears the per-cell search store, has
// the shared square-root unit compute the start heuristic, and then per
// expanded cell scans every open-list entry for the minimum (through the list
// memory and cell memory), moves up every entry behind the one taken out, and
// per neighbour reads map and store and, for a new or cheaper cell, has the
// shared square-root unit compute a new heuristic. The block takes no word
// while a query runs.
// ---------------------------------------------------------------------------
module grid_astar_next_step (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // cell_x, cell_y, cell_code, start_x, start_y, target_x, target_y, pad
   input  logic [asg_pkg::REQ_DATA_W-1:0] req_tdata,
   // cmd
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // next_x, next_y, pad
   output logic [asg_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // path_found
   output logic                           rsp_tuser
);
   import asg_pkg::*;

   // request fields
   logic [COORD_W-1:0] f_cell_x, f_cell_y, f_start_x, f_start_y, f_tgt_x, f_tgt_y;
   logic [7:0]         f_code;

   assign f_cell_x  = req_tdata[4:0];
   assign f_cell_y  = req_tdata[9:5];
   assign f_code    = req_tdata[17:10];
   assign f_start_x = req_tdata[22:18];
   assign f_start_y = req_tdata[27:23];
   assign f_tgt_x   = req_tdata[32:28];
   assign f_tgt_y   = req_tdata[37:33];

   // sequencer state
   state_type          state_ff, state_in;
   logic [CELL_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [LIST_W-1:0]  scan_ff, scan_in;
   logic [LIST_W-1:0]  best_ff, best_in;
   logic [LIST_W-1:0]  pop_ff, pop_in;
   cell_word_type      best_word_ff, best_word_in;
   logic [CELL_W-1:0]  cur_ff, cur_in;
   logic [CELL_W-1:0]  scan_cell_ff, scan_cell_in;
   logic [DIR_W-1:0]   dir_ff, dir_in;
   logic [CELL_W-1:0]  nb_ff, nb_in;
   logic               nb_new_ff, nb_new_in;
   logic [G_W-1:0]     new_g_ff, new_g_in;
   logic [CELL_W-1:0]  si_ff, si_in;
   logic [CELL_W-1:0]  ti_ff, ti_in;
   logic               res_found_ff, res_found_in;
   logic [COORD_W-1:0] res_x_ff, res_x_in;
   logic [COORD_W-1:0] res_y_ff, res_y_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [COORD_W-1:0] rsp_x_ff, rsp_x_in;
   logic [COORD_W-1:0] rsp_y_ff, rsp_y_in;

   // memory ports
   logic               blk_we, blk_wd, blk_re;
   logic [CELL_W-1:0]  blk_wa, blk_ra;
   logic               blk_rd_ff;
   logic               cell_we, cell_re;
   logic [CELL_W-1:0]  cell_wa, cell_ra;
   cell_word_type      cell_wd;
   cell_word_type      cell_rd_ff;
   logic               ord_we, ord_re;
   logic [LIST_W-1:0]  ord_wa, ord_ra;
   logic [CELL_W-1:0]  ord_wd;
   logic [CELL_W-1:0]  ord_rd_ff;

   logic               blk_mem  [CELLS];
   cell_word_type      cell_mem [CELLS];
   logic [CELL_W-1:0]  ord_mem  [LIST_DEPTH];

   // shared square-root unit
   sq_req_type         sq_req;
   sq_rsp_type         sq_rsp;

   asg_sqrt u_sqrt (
      .clock  (clock),
      .reset  (reset),
      .sq_req (sq_req),
      .sq_rsp (sq_rsp)
   );

   logic [COORD_W-1:0] cur_x, cur_y, tgt_x, tgt_y;
   move_type           nb_mv, walk_mv;
   logic [CELL_W-1:0]  nb_idx, walk_idx;
   logic [F_W-1:0]     f_new;
   state_type          adv_state;
   logic [DIR_W-1:0]   adv_dir;

   assign cur_x    = cur_ff[COORD_W-1:0];
   assign cur_y    = cur_ff[CELL_W-1:COORD_W];
   assign tgt_x    = ti_ff[COORD_W-1:0];
   assign tgt_y    = ti_ff[CELL_W-1:COORD_W];
   assign nb_mv    = step_move(cur_x, cur_y, dir_ff, 1'b0);
   assign walk_mv  = step_move(cur_x, cur_y, cell_rd_ff.parent, 1'b1);
   assign nb_idx   = {nb_mv.y, nb_mv.x};
   assign walk_idx = {walk_mv.y, walk_mv.x};
   assign f_new    = (F_W'(new_g_ff) << FRAC_BITS) + F_W'(sq_rsp.root);
   assign adv_state = (dir_ff == DIR_RIGHT) ? S_SEL : S_NB_CHK;
   assign adv_dir   = dir_ff + DIR_W'(1);

   assign req_tready = (state_ff == S_IDLE);

   // sequencer: next state, memory ports and result
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      scan_in      = scan_ff;
      best_in      = best_ff;
      pop_in       = pop_ff;
      best_word_in = best_word_ff;
      cur_in       = cur_ff;
      scan_cell_in = scan_cell_ff;
      dir_in       = dir_ff;
      nb_in        = nb_ff;
      nb_new_in    = nb_new_ff;
      new_g_in     = new_g_ff;
      si_in        = si_ff;
      ti_in        = ti_ff;
      res_found_in = res_found_ff;
      res_x_in     = res_x_ff;
      res_y_in     = res_y_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      blk_we  = 1'b0;  blk_wa  = '0;  blk_wd = 1'b0;
      blk_re  = 1'b0;  blk_ra  = '0;
      cell_we = 1'b0;  cell_wa = '0;  cell_wd = '0;
      cell_re = 1'b0;  cell_ra = '0;
      ord_we  = 1'b0;  ord_wa  = '0;  ord_wd = '0;
      ord_re  = 1'b0;  ord_ra  = '0;
      sq_req  = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_BOOT: begin
            blk_we = 1'b1;
            blk_wa = idx_ff;
            idx_in = idx_ff + CELL_W'(1);
            if (idx_ff == CELL_W'(CELLS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == CMD_WRITE) begin
                  blk_we = 1'b1;
                  blk_wa = {f_cell_y, f_cell_x};
                  blk_wd = (f_code == OBSTACLE_CODE);
               end else begin
                  si_in = {f_start_y, f_start_x};
                  ti_in = {f_tgt_y, f_tgt_x};
                  if (f_start_x == f_tgt_x && f_start_y == f_tgt_y) begin
                     res_found_in = 1'b1;
                     res_x_in     = f_start_x;
                     res_y_in     = f_start_y;
                     state_in     = S_REPLY;
                  end else begin
                     idx_in   = '0;
                     state_in = S_CLEAR;
                  end
               end
            end
         end
         S_CLEAR: begin
            cell_we = 1'b1;
            cell_wa = idx_ff;
            idx_in  = idx_ff + CELL_W'(1);
            if (idx_ff == CELL_W'(CELLS - 1)) begin
               sq_req.start = 1'b1;
               sq_req.dx    = abs_diff(si_ff[COORD_W-1:0], tgt_x);
               sq_req.dy    = abs_diff(si_ff[CELL_W-1:COORD_W], tgt_y);
               state_in     = S_START_H;
            end
         end
         S_START_H: begin
            if (sq_rsp.done) begin
               cell_we        = 1'b1;
               cell_wa        = si_ff;
               cell_wd.mark   = MARK_OPEN;
               cell_wd.g      = '0;
               cell_wd.parent = DIR_UP;
               cell_wd.f      = F_W'(sq_rsp.root);
               ord_we         = 1'b1;
               ord_wa         = '0;
               ord_wd         = si_ff;
               cnt_in         = CNT_W'(1);
               state_in       = S_SEL;
            end
         end
         S_SEL: begin
            if (cnt_ff == '0) begin
               res_found_in = 1'b0;
               res_x_in     = '0;
               res_y_in     = '0;
               state_in     = S_REPLY;
            end else begin
               ord_re   = 1'b1;
               ord_ra   = '0;
               scan_in  = '0;
               state_in = S_SCAN_CELL;
            end
         end
         S_SCAN_CELL: begin
            cell_re      = 1'b1;
            cell_ra      = ord_rd_ff;
            scan_cell_in = ord_rd_ff;
            state_in     = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            // first strict minimum of f wins
            if (scan_ff == '0 || cell_rd_ff.f < best_word_ff.f) begin
               best_word_in = cell_rd_ff;
               best_in      = scan_ff;
               cur_in       = scan_cell_ff;
            end
            if (CNT_W'(scan_ff) + CNT_W'(1) < cnt_ff) begin
               scan_in  = scan_ff + LIST_W'(1);
               ord_re   = 1'b1;
               ord_ra   = scan_ff + LIST_W'(1);
               state_in = S_SCAN_CELL;
            end else begin
               pop_in   = best_in;
               state_in = S_POP_RD;
            end
         end
         S_POP_RD: begin
            if (CNT_W'(pop_ff) + CNT_W'(1) < cnt_ff) begin
               ord_re   = 1'b1;
               ord_ra   = pop_ff + LIST_W'(1);
               state_in = S_POP_WR;
            end else begin
               cnt_in   = cnt_ff - CNT_W'(1);
               state_in = S_CLOSE;
            end
         end
         S_POP_WR: begin
            ord_we   = 1'b1;
            ord_wa   = pop_ff;
            ord_wd   = ord_rd_ff;
            pop_in   = pop_ff + LIST_W'(1);
            state_in = S_POP_RD;
         end
         S_CLOSE: begin
            cell_we      = 1'b1;
            cell_wa      = cur_ff;
            cell_wd      = best_word_ff;
            cell_wd.mark = MARK_CLOSED;
            if (cur_ff == ti_ff) begin
               state_in = S_WALK_RD;
            end else begin
               dir_in   = DIR_UP;
               state_in = S_NB_CHK;
            end
         end
         S_NB_CHK: begin
            if (!nb_mv.ok) begin
               dir_in   = adv_dir;
               state_in = adv_state;
            end else begin
               blk_re   = 1'b1;
               blk_ra   = nb_idx;
               cell_re  = 1'b1;
               cell_ra  = nb_idx;
               nb_in    = nb_idx;
               new_g_in = best_word_ff.g + G_W'(1);
               state_in = S_NB_TEST;
            end
         end
         S_NB_TEST: begin
            sq_req.dx = abs_diff(nb_ff[COORD_W-1:0], tgt_x);
            sq_req.dy = abs_diff(nb_ff[CELL_W-1:COORD_W], tgt_y);
            if (blk_rd_ff || cell_rd_ff.mark == MARK_CLOSED) begin
               dir_in   = adv_dir;
               state_in = adv_state;
            end else if (cell_rd_ff.mark == MARK_OPEN) begin
               if (new_g_ff < cell_rd_ff.g) begin
                  sq_req.start = 1'b1;
                  nb_new_in    = 1'b0;
                  state_in     = S_NB_H;
               end else begin
                  dir_in   = adv_dir;
                  state_in = adv_state;
               end
            end else if (cnt_ff < CNT_W'(LIST_DEPTH)) begin
               sq_req.start = 1'b1;
               nb_new_in    = 1'b1;
               state_in     = S_NB_H;
            end else begin
               dir_in   = adv_dir;
               state_in = adv_state;
            end
         end
         S_NB_H: begin
            if (sq_rsp.done) begin
               cell_we        = 1'b1;
               cell_wa        = nb_ff;
               cell_wd.mark   = MARK_OPEN;
               cell_wd.g      = new_g_ff;
               cell_wd.parent = dir_ff;
               cell_wd.f      = f_new;
               if (nb_new_ff) begin
                  ord_we = 1'b1;
                  ord_wa = cnt_ff[LIST_W-1:0];
                  ord_wd = nb_ff;
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               dir_in   = adv_dir;
               state_in = adv_state;
            end
         end
         S_WALK_RD: begin
            if (cur_ff == si_ff) begin
               res_found_in = 1'b1;
               res_x_in     = cur_x;
               res_y_in     = cur_y;
               state_in     = S_REPLY;
            end else begin
               cell_re  = 1'b1;
               cell_ra  = cur_ff;
               state_in = S_WALK_STEP;
            end
         end
         S_WALK_STEP: begin
            // stop on the cell whose parent is the start
            if (!walk_mv.ok || walk_idx == si_ff) begin
               res_found_in = 1'b1;
               res_x_in     = cur_x;
               res_y_in     = cur_y;
               state_in     = S_REPLY;
            end else begin
               cur_in   = walk_idx;
               state_in = S_WALK_RD;
            end
         end
         S_REPLY: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_x_in     = res_x_ff;
               rsp_y_in     = res_y_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_BOOT;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      scan_ff      <= scan_in;
      best_ff      <= best_in;
      pop_ff       <= pop_in;
      best_word_ff <= best_word_in;
      cur_ff       <= cur_in;
      scan_cell_ff <= scan_cell_in;
      dir_ff       <= dir_in;
      nb_ff        <= nb_in;
      nb_new_ff    <= nb_new_in;
      new_g_ff     <= new_g_in;
      si_ff        <= si_in;
      ti_ff        <= ti_in;
      res_found_ff <= res_found_in;
      res_x_ff     <= res_x_in;
      res_y_ff     <= res_y_in;
      rsp_found_ff <= rsp_found_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
   end

   // obstacle map
   always_ff @(posedge clock) begin
      if (blk_we) begin
         blk_mem[blk_wa] <= blk_wd;
      end
      if (blk_re) begin
         blk_rd_ff <= blk_mem[blk_ra];
      end
   end

   // per-cell search store: mark, cost, parent, estimate
   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[cell_wa] <= cell_wd;
      end
      if (cell_re) begin
         cell_rd_ff <= cell_mem[cell_ra];
      end
   end

   // open list in insertion order
   always_ff @(posedge clock) begin
      if (ord_we) begin
         ord_mem[ord_wa] <= ord_wd;
      end
      if (ord_re) begin
         ord_rd_ff <= ord_mem[ord_ra];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - CELL_W){1'b0}}, rsp_y_ff, rsp_x_ff};

   // checks
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(LIST_DEPTH))
      else $error("open list count beyond depth");

   a_sq_idle: assert property (@(posedge clock) disable iff (reset)
      sq_req.start |-> !sq_rsp.busy)
      else $error("square-root unit started while busy");

   a_reply_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REPLY && (!rsp_valid_ff || rsp_tready)) |=> rsp_valid_ff)
      else $error("result word not loaded");

   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_x_ff == '0 && rsp_y_ff == '0))
      else $error("not-found word carries a cell");

endmodule
